// File: design/assert_macros.svh
// Assertion macros shared by the address pool RTL.
// No dependencies; SYNTH selects the empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define APLNAT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define APLNAT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define APLNAT_ASSERT(lbl, clk, rstn, prop, msg)
`define APLNAT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// File: design/aplnat_pkg.sv
// Types, constants and codes for the NAT address pool with lease timeout.
// Used by the controller, the datapath and the top level.
`default_nettype none
package aplnat_pkg;

  localparam int unsigned POOL_SIZE_DEF = 256;
  localparam logic [31:0] LEASE_RESET = 32'd300;
  localparam logic [31:0] POOL_BASE_RESET = 32'hC0A8_6400;  // 192.168.100.0

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 1'b1;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NEW = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_OUTSIDE = 2'd3;

  localparam logic OP_TUNNEL = 1'b0;
  localparam logic OP_CLIENT = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] now;
    logic [31:0] local_addr;
    logic [31:0] inner_addr;
    logic [31:0] outer_addr;
    logic [15:0] outer_port;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] mapped_addr;
    logic [31:0] dest_outer_addr;
    logic [15:0] dest_outer_port;
  } out_res_t;

  typedef struct packed {
    logic [31:0] inner_addr;
    logic [31:0] outer_addr;
    logic [15:0] outer_port;
    logic [31:0] last_seen;
  } slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TUN,
    S_TUN_WR,
    S_SCAN,
    S_ALLOC
  } state_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_SCAN,
    RD_TUN
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ZERO,
    WR_TOUCH,
    WR_ALLOC
  } wr_sel_t;

  typedef enum logic [2:0] {
    RES_TUN,
    RES_HIT,
    RES_NEW,
    RES_FULL,
    RES_OUTSIDE
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     track;
    rd_sel_t  rd;
    wr_sel_t  wr;
    logic     finish;
    res_sel_t res;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic scan_more;
    logic clr_last;
    logic hit;
    logic rd_last;
    logic avail_found;
  } sts_t;

endpackage
`default_nettype wire

// File: design/aplnat_datapath.sv
// Datapath of the address pool: slot memory, request and config registers,
// scan counter, match and lease checks, result register. Uses aplnat_pkg.
`default_nettype none
`include "assert_macros.svh"
module aplnat_datapath #(
  parameter int unsigned POOL_SIZE = aplnat_pkg::POOL_SIZE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire aplnat_pkg::in_req_t              in_payload,
  input  wire logic                             cfg_we,
  input  wire logic [aplnat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                      cfg_wdata,
  input  wire aplnat_pkg::cmd_t                 cmd_i,
  output aplnat_pkg::sts_t                      sts_o,
  output logic                                  out_strobe,
  output aplnat_pkg::out_res_t                  out_payload
);

  localparam int unsigned IDX_W = $clog2(POOL_SIZE);
  localparam int unsigned CNT_W = $clog2(POOL_SIZE + 1);

  aplnat_pkg::slot_t slot_mem [POOL_SIZE];

  logic [31:0]          lease_r;
  logic [31:0]          base_r;
  aplnat_pkg::in_req_t  req_r;
  logic [CNT_W-1:0]     scan_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;
  aplnat_pkg::slot_t    rd_data_r;
  logic                 avail_found_r;
  logic [IDX_W-1:0]     avail_idx_r;
  logic                 out_strobe_r;
  aplnat_pkg::out_res_t out_r;

  logic [31:0]          offset;
  logic [31:0]          age;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  aplnat_pkg::slot_t    wr_data;
  logic                 hit;
  logic                 avail;
  aplnat_pkg::out_res_t res_nxt;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lease_r <= aplnat_pkg::LEASE_RESET;
      base_r  <= aplnat_pkg::POOL_BASE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == aplnat_pkg::CFG_LEASE_TIMEOUT) begin
        lease_r <= cfg_wdata;
      end
      if (cfg_index == aplnat_pkg::CFG_POOL_BASE) begin
        base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      req_r <= in_payload;
    end
  end

  assign offset = req_r.local_addr - base_r;
  assign age    = req_r.now - rd_data_r.last_seen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else if (cmd_i.cnt_clr) begin
      scan_r <= '0;
    end else if (cmd_i.cnt_inc) begin
      scan_r <= scan_r + CNT_W'(1);
    end
  end

  // read port
  assign rd_en   = (cmd_i.rd != aplnat_pkg::RD_NONE);
  assign rd_addr = (cmd_i.rd == aplnat_pkg::RD_TUN) ? offset[IDX_W-1:0] : scan_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx_r <= rd_addr;
    end
  end

  // write port
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = rd_idx_r;
    wr_data = rd_data_r;
    wr_data.last_seen = req_r.now;
    unique case (cmd_i.wr)
      aplnat_pkg::WR_NONE: begin
        wr_en = 1'b0;
      end
      aplnat_pkg::WR_ZERO: begin
        wr_addr = scan_r[IDX_W-1:0];
        wr_data = '0;
      end
      aplnat_pkg::WR_TOUCH: begin
        wr_addr = rd_idx_r;
      end
      aplnat_pkg::WR_ALLOC: begin
        wr_addr = avail_idx_r;
        wr_data = '{inner_addr: req_r.inner_addr, outer_addr: req_r.outer_addr,
                    outer_port: req_r.outer_port, last_seen: req_r.now};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem[rd_addr];
    end
  end

  // match and lease checks on the slot just read
  assign hit = rd_vld_r && (rd_data_r.inner_addr != 32'd0)
            && (rd_data_r.inner_addr == req_r.inner_addr)
            && (rd_data_r.outer_addr == req_r.outer_addr)
            && (rd_data_r.outer_port == req_r.outer_port);
  assign avail = rd_vld_r && ((rd_data_r.inner_addr == 32'd0) || (age > lease_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_found_r <= 1'b0;
    end else if (cmd_i.load) begin
      avail_found_r <= 1'b0;
    end else if (cmd_i.track && avail && !avail_found_r) begin
      avail_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.track && avail && !avail_found_r) begin
      avail_idx_r <= rd_idx_r;
    end
  end

  always_comb begin
    sts_o.in_range    = (offset < 32'(POOL_SIZE));
    sts_o.scan_more   = (scan_r < CNT_W'(POOL_SIZE));
    sts_o.clr_last    = (scan_r == CNT_W'(POOL_SIZE - 1));
    sts_o.hit         = hit;
    sts_o.rd_last     = rd_vld_r && (rd_idx_r == IDX_W'(POOL_SIZE - 1));
    sts_o.avail_found = avail_found_r;
  end

  // result register
  always_comb begin
    res_nxt = '0;
    unique case (cmd_i.res)
      aplnat_pkg::RES_TUN: begin
        res_nxt.status          = aplnat_pkg::ST_FOUND;
        res_nxt.mapped_addr     = rd_data_r.inner_addr;
        res_nxt.dest_outer_addr = rd_data_r.outer_addr;
        res_nxt.dest_outer_port = rd_data_r.outer_port;
      end
      aplnat_pkg::RES_HIT: begin
        res_nxt.status      = aplnat_pkg::ST_FOUND;
        res_nxt.mapped_addr = base_r + 32'(rd_idx_r);
      end
      aplnat_pkg::RES_NEW: begin
        res_nxt.status      = aplnat_pkg::ST_NEW;
        res_nxt.mapped_addr = base_r + 32'(avail_idx_r);
      end
      aplnat_pkg::RES_FULL: begin
        res_nxt.status = aplnat_pkg::ST_FULL;
      end
      aplnat_pkg::RES_OUTSIDE: begin
        res_nxt.status = aplnat_pkg::ST_OUTSIDE;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.finish) begin
      out_r <= res_nxt;
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_payload = out_r;

  `APLNAT_NEVER(a_alloc_needs_slot, clk, rst_n, cmd_i.wr == aplnat_pkg::WR_ALLOC && !avail_found_r, "allocation without a free slot")
  `APLNAT_ASSERT(a_hit_has_data, clk, rst_n, (cmd_i.finish && cmd_i.res == aplnat_pkg::RES_HIT) |-> hit, "hit reported without a match")
  `APLNAT_ASSERT(a_strobe_single, clk, rst_n, out_strobe_r |-> $past(cmd_i.finish), "result strobe without finish")

endmodule
`default_nettype wire

// File: design/aplnat_ctrl.sv
// Controller state machine of the address pool: clearing pass, tunnel
// lookup, client scan and allocation. Uses aplnat_pkg.
`default_nettype none
`include "assert_macros.svh"
module aplnat_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             in_op,
  input  wire aplnat_pkg::sts_t sts_i,
  output aplnat_pkg::cmd_t      cmd_o,
  output logic                  busy
);

  aplnat_pkg::state_t state_r;
  aplnat_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aplnat_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aplnat_pkg::S_CLEAR: begin
        if (sts_i.clr_last) state_nxt = aplnat_pkg::S_IDLE;
      end
      aplnat_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (in_op == aplnat_pkg::OP_CLIENT) ? aplnat_pkg::S_SCAN
                                                        : aplnat_pkg::S_TUN;
        end
      end
      aplnat_pkg::S_TUN: begin
        state_nxt = sts_i.in_range ? aplnat_pkg::S_TUN_WR : aplnat_pkg::S_IDLE;
      end
      aplnat_pkg::S_TUN_WR: begin
        state_nxt = aplnat_pkg::S_IDLE;
      end
      aplnat_pkg::S_SCAN: begin
        priority if (sts_i.hit) begin
          state_nxt = aplnat_pkg::S_IDLE;
        end else if (sts_i.rd_last) begin
          state_nxt = aplnat_pkg::S_ALLOC;
        end else begin
          state_nxt = aplnat_pkg::S_SCAN;
        end
      end
      aplnat_pkg::S_ALLOC: begin
        state_nxt = aplnat_pkg::S_IDLE;
      end
      default: begin
        state_nxt = aplnat_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '{load: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b0, track: 1'b0,
              rd: aplnat_pkg::RD_NONE, wr: aplnat_pkg::WR_NONE,
              finish: 1'b0, res: aplnat_pkg::RES_FULL};
    busy  = 1'b1;
    unique case (state_r)
      aplnat_pkg::S_CLEAR: begin
        cmd_o.wr      = aplnat_pkg::WR_ZERO;
        cmd_o.cnt_inc = 1'b1;
      end
      aplnat_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load    = 1'b1;
          cmd_o.cnt_clr = 1'b1;
        end
      end
      aplnat_pkg::S_TUN: begin
        if (sts_i.in_range) begin
          cmd_o.rd = aplnat_pkg::RD_TUN;
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.res    = aplnat_pkg::RES_OUTSIDE;
        end
      end
      aplnat_pkg::S_TUN_WR: begin
        cmd_o.wr     = aplnat_pkg::WR_TOUCH;
        cmd_o.finish = 1'b1;
        cmd_o.res    = aplnat_pkg::RES_TUN;
      end
      aplnat_pkg::S_SCAN: begin
        cmd_o.track = 1'b1;
        if (sts_i.scan_more) begin
          cmd_o.rd      = aplnat_pkg::RD_SCAN;
          cmd_o.cnt_inc = 1'b1;
        end
        if (sts_i.hit) begin
          cmd_o.wr     = aplnat_pkg::WR_TOUCH;
          cmd_o.finish = 1'b1;
          cmd_o.res    = aplnat_pkg::RES_HIT;
        end
      end
      aplnat_pkg::S_ALLOC: begin
        cmd_o.finish = 1'b1;
        if (sts_i.avail_found) begin
          cmd_o.wr  = aplnat_pkg::WR_ALLOC;
          cmd_o.res = aplnat_pkg::RES_NEW;
        end else begin
          cmd_o.res = aplnat_pkg::RES_FULL;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `APLNAT_ASSERT(a_accept_dispatch, clk, rst_n, (state_r == aplnat_pkg::S_IDLE && start) |=> (state_r == aplnat_pkg::S_TUN || state_r == aplnat_pkg::S_SCAN), "accepted request not dispatched")
  `APLNAT_ASSERT(a_finish_to_idle, clk, rst_n, cmd_o.finish |=> (state_r == aplnat_pkg::S_IDLE), "finish did not return to idle")

endmodule
`default_nettype wire

// File: design/address_pool_lease_nat.sv
// Top level of the NAT address pool with lease timeout.
// Instantiates aplnat_ctrl and aplnat_datapath; types from aplnat_pkg.
//
// Usage: the pool holds POOL_SIZE slots, slot i standing for local address
// pool_base + i. A request is taken at a rising edge with start high and
// busy low. Exactly one result follows for every request, shown for one
// cycle with out_strobe high; the receiver cannot stall it, so capture it
// when the strobe is seen. After reset the block runs a clearing pass over
// the slot memory, one slot a cycle, and holds busy high until the pass
// ends; configuration writes are taken during that pass as at any time.
// A tunnel request (op 0) reads and touches its slot, or answers with no
// slot read if its address lies outside the pool. A client request (op 1)
// walks the slot memory one slot a cycle through its single read port: a
// match ends the walk, while a miss walks the whole pool before it answers
// (new lease or pool full). busy drops in the cycle the result register
// loads, so the next request can be taken while the strobe is shown.
// Configure lease_timeout (index 0) and pool_base (index 1) only while idle.
`default_nettype none
module address_pool_lease_nat #(
  parameter int unsigned POOL_SIZE = aplnat_pkg::POOL_SIZE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire aplnat_pkg::in_req_t              in_payload,
  output logic                                  out_strobe,
  output aplnat_pkg::out_res_t                  out_payload,
  input  wire logic                             cfg_we,
  input  wire logic [aplnat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                      cfg_wdata
);

  // command and status between the controller and the datapath
  aplnat_pkg::cmd_t cmd;
  aplnat_pkg::sts_t sts;

  // sequence clear, tunnel lookup, scan and allocate
  aplnat_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_payload.op),
    .sts_i (sts),
    .cmd_o (cmd),
    .busy  (busy)
  );

  // hold the slots, the request and the result
  aplnat_datapath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_strobe  (out_strobe),
    .out_payload (out_payload)
  );

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for address_pool_lease_nat: lease allocation, hits, expiry, tunnel lookups.
// Holds its own model of the slot table; depends on aplnat_pkg and the top level only.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int unsigned POOL = aplnat_pkg::POOL_SIZE_DEF;
  // Cycles without any accepted request or result before the run is given up.
  // The slowest quiet spell is reset and the clearing pass followed by the
  // longest sender gap, so this leaves ample margin.
  localparam int WATCHDOG_LIMIT = 5000;

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  aplnat_pkg::in_req_t              in_payload;
  logic                             out_strobe;
  aplnat_pkg::out_res_t             out_payload;
  logic                             cfg_we;
  logic [aplnat_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                      cfg_wdata;

  address_pool_lease_nat u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_payload  (in_payload),
    .out_strobe  (out_strobe),
    .out_payload (out_payload),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  // Our own copy of the slot table and the two registers.
  logic [31:0] slot_inner_m [POOL];
  logic [31:0] slot_outer_m [POOL];
  logic [15:0] slot_port_m  [POOL];
  logic [31:0] slot_seen_m  [POOL];
  logic [31:0] lease_m;
  logic [31:0] base_m;

  aplnat_pkg::out_res_t lookup_answers[$];  // answers still owed by the block, oldest first
  int       mismatches;
  int       quiet_cycles;
  bit       steady;             // set to suppress sender idling for a stretch

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the answer to one request and apply its effect on the table.
  function automatic aplnat_pkg::out_res_t lease_lookup(input aplnat_pkg::in_req_t r);
    aplnat_pkg::out_res_t res;
    logic [31:0] idx;
    logic [31:0] age;
    int          hit;
    int          avail;
    res   = '0;
    hit   = -1;
    avail = -1;
    if (r.op == aplnat_pkg::OP_TUNNEL) begin
      idx = r.local_addr - base_m;
      if (idx >= POOL) begin
        res.status = aplnat_pkg::ST_OUTSIDE;
      end else begin
        // A free slot answers too, with its zero contents; touch it anyway.
        slot_seen_m[idx]    = r.now;
        res.status          = aplnat_pkg::ST_FOUND;
        res.mapped_addr     = slot_inner_m[idx];
        res.dest_outer_addr = slot_outer_m[idx];
        res.dest_outer_port = slot_port_m[idx];
      end
      return res;
    end
    // A matching used slot wins over any lower free or expired slot.
    for (int i = 0; i < POOL; i++) begin
      if (hit < 0 && slot_inner_m[i] != 32'd0 && slot_inner_m[i] == r.inner_addr &&
          slot_outer_m[i] == r.outer_addr && slot_port_m[i] == r.outer_port)
        hit = i;
    end
    if (hit >= 0) begin
      slot_seen_m[hit] = r.now;
      res.status       = aplnat_pkg::ST_FOUND;
      res.mapped_addr  = base_m + 32'(hit);
      return res;
    end
    for (int i = 0; i < POOL; i++) begin
      age = r.now - slot_seen_m[i];
      if (avail < 0 && (slot_inner_m[i] == 32'd0 || age > lease_m))
        avail = i;
    end
    if (avail >= 0) begin
      // Inner address zero still takes the slot, which then stays free.
      slot_inner_m[avail] = r.inner_addr;
      slot_outer_m[avail] = r.outer_addr;
      slot_port_m[avail]  = r.outer_port;
      slot_seen_m[avail]  = r.now;
      res.status          = aplnat_pkg::ST_NEW;
      res.mapped_addr     = base_m + 32'(avail);
    end else begin
      res.status = aplnat_pkg::ST_FULL;
    end
    return res;
  endfunction

  function automatic aplnat_pkg::in_req_t client_req(input logic [31:0] t,
                                                     input logic [31:0] inner,
                                                     input logic [31:0] outer,
                                                     input logic [15:0] port);
    aplnat_pkg::in_req_t r;
    r.op         = aplnat_pkg::OP_CLIENT;
    r.now        = t;
    r.local_addr = $urandom();  // unused by a client request, keep it noisy
    r.inner_addr = inner;
    r.outer_addr = outer;
    r.outer_port = port;
    return r;
  endfunction

  function automatic aplnat_pkg::in_req_t tunnel_req(input logic [31:0] t,
                                                     input logic [31:0] dest);
    aplnat_pkg::in_req_t r;
    r.op         = aplnat_pkg::OP_TUNNEL;
    r.now        = t;
    r.local_addr = dest;
    r.inner_addr = $urandom();
    r.outer_addr = $urandom();
    r.outer_port = 16'($urandom());
    return r;
  endfunction

  // Send one request: maybe idle first, then hold start until busy is low at
  // an edge. start stays high on return so back-to-back requests need no
  // second assignment in the same step; wait_answers drops it.
  task automatic issue_packet(input aplnat_pkg::in_req_t r);
    int gap;
    if (!steady && $urandom_range(99) < 37) begin
      // Mostly short gaps; now and then one long enough to land mid-scan.
      gap = ($urandom_range(9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_payload <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    lookup_answers.push_back(lease_lookup(r));
  endtask

  // Drop start and hold until every owed answer has been seen.
  task automatic wait_answers();
    start <= 1'b0;
    while (lookup_answers.size() != 0) @(posedge clk);
  endtask

  // Write both registers while the block is idle.
  task automatic set_config(input logic [31:0] lease, input logic [31:0] base);
    wait_answers();
    cfg_we    <= 1'b1;
    cfg_index <= aplnat_pkg::CFG_LEASE_TIMEOUT;
    cfg_wdata <= lease;
    @(posedge clk);
    lease_m = lease;
    cfg_index <= aplnat_pkg::CFG_POOL_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    base_m = base;
    cfg_we <= 1'b0;
  endtask

  // Random traffic: a set of returning clients with random addresses, fresh
  // clients at the given share, tunnel packets mostly to leased slots, and
  // some noise. Time advances by up to step_max per request.
  task automatic run_traffic(input int n, input int nclients, input logic [31:0] step_max,
                             input int fresh_pct, input logic [31:0] t0);
    logic [31:0] c_inner [32];
    logic [31:0] c_outer [32];
    logic [15:0] c_port  [32];
    logic [31:0] t;
    logic [31:0] dest;
    aplnat_pkg::in_req_t r;
    int          roll;
    int          j;
    for (int i = 0; i < nclients; i++) begin
      c_inner[i] = $urandom();
      c_outer[i] = $urandom();
      c_port[i]  = 16'($urandom());
    end
    t = t0;
    for (int k = 0; k < n; k++) begin
      steady = (k >= n / 3) && (k < n / 3 + n / 6);
      t = t + $urandom_range(0, step_max);
      if ($urandom_range(99) < fresh_pct) begin
        r = client_req(t, $urandom(), $urandom(), 16'($urandom()));
      end else begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          j = $urandom_range(0, nclients - 1);
          r = client_req(t, c_inner[j], c_outer[j], c_port[j]);
        end else if (roll < 80) begin
          r = tunnel_req(t, base_m + 32'($urandom_range(0, nclients + 3)));
        end else if (roll < 90) begin
          r = tunnel_req(t, base_m + 32'($urandom_range(0, POOL - 1)));
        end else if (roll < 95) begin
          if ($urandom_range(1)) dest = $urandom();
          else dest = $urandom_range(1) ? base_m - 32'd1 : base_m + 32'(POOL);
          r = tunnel_req(t, dest);
        end else if (roll < 98) begin
          r = client_req(t, 32'd0, $urandom(), 16'($urandom()));
        end else begin
          j = $urandom_range(0, nclients - 1);
          r = client_req($urandom(), c_inner[j], c_outer[j], c_port[j]);
        end
      end
      issue_packet(r);
      if ($urandom_range(99) < 2) wait_answers();
    end
    steady = 1'b0;
  endtask

  // Default registers straight after reset: allocate, hit, tunnel lookups,
  // out-of-pool addresses, a free slot, inner address zero, field extremes.
  task automatic test_defaults();
    issue_packet(client_req(32'd10, 32'h0A00_0001, 32'h0102_0304, 16'd5000));
    issue_packet(client_req(32'd20, 32'h0A00_0001, 32'h0102_0304, 16'd5000));
    issue_packet(tunnel_req(32'd30, base_m));
    issue_packet(tunnel_req(32'd31, base_m + 32'(POOL - 1)));
    issue_packet(tunnel_req(32'd32, base_m - 32'd1));
    issue_packet(tunnel_req(32'd33, base_m + 32'(POOL)));
    issue_packet(client_req(32'd40, 32'd0, 32'h5555_AAAA, 16'h00FF));
    issue_packet(client_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    // Time wrapped to zero: older leases look ancient and get reclaimed.
    issue_packet(client_req(32'd0, 32'd1, 32'd0, 16'd0));
    issue_packet(tunnel_req(32'd1, base_m + 32'd1));
    wait_answers();
  endtask

  // Lease expiry at a short timeout, at zero and at the largest timeout.
  task automatic test_lease_expiry();
    set_config(32'd10, aplnat_pkg::POOL_BASE_RESET);
    issue_packet(client_req(32'd1000, 32'h0B00_0001, 32'h0808_0808, 16'd1111));
    issue_packet(client_req(32'd1000, 32'h0B00_0002, 32'h0808_0404, 16'd2222));
    // Both leases have run out; the second client still hits its own slot.
    issue_packet(client_req(32'd1100, 32'h0B00_0002, 32'h0808_0404, 16'd2222));
    issue_packet(client_req(32'd1100, 32'h0B00_0003, 32'h0101_0101, 16'd3333));
    set_config(32'd0, aplnat_pkg::POOL_BASE_RESET);
    issue_packet(client_req(32'd2000, 32'h0C00_0001, 32'h0202_0202, 16'd1));
    issue_packet(client_req(32'd2000, 32'h0C00_0002, 32'h0202_0203, 16'd2));
    issue_packet(client_req(32'd2001, 32'h0C00_0003, 32'h0202_0204, 16'd3));
    set_config(32'hFFFF_FFFF, aplnat_pkg::POOL_BASE_RESET);
    issue_packet(client_req(32'd5, 32'h0D00_0001, 32'h0303_0303, 16'd4));
    issue_packet(client_req(32'd0, 32'h0D00_0002, 32'h0303_0304, 16'd5));
    wait_answers();
  endtask

  // Pool base near the top of the address space, so the pool wraps, then zero.
  task automatic test_pool_wrap();
    set_config(32'd300, 32'hFFFF_FF80);
    issue_packet(tunnel_req(32'd50, 32'h0000_007F));
    issue_packet(tunnel_req(32'd51, 32'h0000_0080));
    issue_packet(tunnel_req(32'd52, 32'hFFFF_FF7F));
    issue_packet(client_req(32'd53, 32'h0E00_0001, 32'h0404_0404, 16'd6));
    set_config(32'd300, 32'd0);
    issue_packet(tunnel_req(32'd54, 32'hFFFF_FFFF));
    issue_packet(tunnel_req(32'd55, 32'd0));
    wait_answers();
  endtask

  // Short leases with a small client set: hits, reclaims and tunnel traffic.
  task automatic test_churn();
    set_config($urandom_range(5, 40), $urandom());
    run_traffic(250, 16, 32'd8, 8, $urandom());
  endtask

  // Leases never run out and most clients are new, so the pool fills up.
  task automatic test_pool_full();
    set_config(32'hFFFF_FFFF, $urandom());
    run_traffic(380, 16, 32'd3, 70, $urandom());
  endtask

  // Random timeout, random base and time jumping anywhere; then zero timeout near the wrap.
  task automatic test_random_config();
    set_config($urandom(), $urandom());
    run_traffic(200, 24, 32'hFFFF_FFFF, 10, $urandom());
    set_config(32'd0, 32'hFFFF_FFFF);
    run_traffic(70, 8, 32'd2, 20, 32'hFFFF_FFF0);
  endtask

  // Compare each strobed result with the oldest owed answer.
  always @(posedge clk) begin : check_answers
    aplnat_pkg::out_res_t want;
    if (rst_n && out_strobe) begin
      if (lookup_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d mapped %h dest %h:%0d",
                   out_payload.status, out_payload.mapped_addr,
                   out_payload.dest_outer_addr, out_payload.dest_outer_port);
      end else begin
        want = lookup_answers.pop_front();
        if (out_payload.status !== want.status ||
            out_payload.mapped_addr !== want.mapped_addr ||
            out_payload.dest_outer_addr !== want.dest_outer_addr ||
            out_payload.dest_outer_port !== want.dest_outer_port) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected status %0d mapped %h dest %h:%0d,",
                      " got status %0d mapped %h dest %h:%0d"},
                     want.status, want.mapped_addr, want.dest_outer_addr,
                     want.dest_outer_port, out_payload.status, out_payload.mapped_addr,
                     out_payload.dest_outer_addr, out_payload.dest_outer_port);
        end
      end
    end
  end

  // Give up when nothing moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_payload   = '0;
    cfg_we       = 1'b0;
    cfg_index    = aplnat_pkg::CFG_LEASE_TIMEOUT;
    cfg_wdata    = 32'd0;
    mismatches   = 0;
    quiet_cycles = 0;
    steady       = 1'b0;
    lease_m      = aplnat_pkg::LEASE_RESET;
    base_m       = aplnat_pkg::POOL_BASE_RESET;
    for (int i = 0; i < POOL; i++) begin
      slot_inner_m[i] = 32'd0;
      slot_outer_m[i] = 32'd0;
      slot_port_m[i]  = 16'd0;
      slot_seen_m[i]  = 32'd0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // Hold off until the clearing pass over the slot memory is done.
    @(posedge clk);
    while (busy) @(posedge clk);

    test_defaults();
    test_lease_expiry();
    test_pool_wrap();
    test_churn();
    test_pool_full();
    test_random_config();

    wait_answers();
    // Leave room for any stray result from a full scan.
    repeat (POOL + 8) @(posedge clk);
    if (mismatches == 0 && lookup_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
+incdir+design
design/aplnat_pkg.sv
design/aplnat_datapath.sv
design/aplnat_ctrl.sv
design/address_pool_lease_nat.sv
tb/sv/tb.sv
